// ===== rtl/pihc_pkg.sv =====
// ============================================================================
// pihc_pkg
// Shared types, widths and constants of the PI heater temperature controller.
// ============================================================================
package pihc_pkg;

    // Field widths
    localparam int TEMP_W    = 16;
    localparam int TS_W      = 32;
    localparam int DUTY_W    = 14;
    localparam int INTEG_W   = 24;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 23;
    localparam int ERR_W     = TEMP_W + 1;

    // Shared multiplier: signed A x signed B, registered product
    localparam int MUL_A_W   = TS_W + 1;
    localparam int MUL_B_W   = TS_W + 1;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // Division by the time-scale constant through the shared multiplier
    // err*dt*256/1e6 == |err*dt|*4/15625, |err*dt| < 2^48
    // Long division in two 32-bit steps, each a reciprocal multiplication:
    // floor(n/15625) == (n*RECIP) >> RECIP_SHIFT for every 32-bit n
    localparam int DIV_N_W     = 50;
    localparam int DIV_LO_W    = 18;
    localparam int DIV_HI_W    = DIV_N_W - DIV_LO_W;
    localparam int DIV_REM_W   = 14;
    localparam int DIV_QH_W    = 19;
    localparam int DIV_QL_W    = 18;
    localparam int DIV_Q_W     = DIV_QH_W + DIV_QL_W;
    localparam int RECIP_SHIFT = 45;
    localparam logic [DIV_REM_W-1:0] DIVISOR = 14'd15625;
    localparam logic [DIV_HI_W-1:0]  RECIP   = 32'd2251799814;

    // Drive path
    localparam int DRIVE_W   = 25;
    localparam int SUM_W     = 42;
    localparam int PTERM_W   = 33;
    localparam int ITERM_W   = 40;
    localparam logic [DRIVE_W-1:0] DRIVE_ONE = 25'h100_0000;
    localparam int DRIVE_FRAC = 24;

    // Configuration port
    localparam int CFG_DATA_W = 23;
    localparam int PWM_TOP_DEF = 9999;

    localparam logic signed [TEMP_W-1:0] SETPOINT_RST    = 16'sd14080;
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST   = 16'd77;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST  = 16'd51;
    localparam logic [LIMIT_W-1:0]       INTEG_LIMIT_RST = 23'd32768;

    typedef enum logic [1:0] {
        REG_SETPOINT    = 2'd0,
        REG_PROP_GAIN   = 2'd1,
        REG_INTEG_GAIN  = 2'd2,
        REG_INTEG_LIMIT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [TS_W-1:0]          timestamp_us;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_W-1:0]         duty_count;
        logic signed [INTEG_W-1:0] integral_out;
    } out_word_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] setpoint;
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        integ_gain;
        logic [LIMIT_W-1:0]       integ_limit;
    } cfg_t;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_HI,
        DIV_REM,
        DIV_LO,
        DIV_FIN
    } div_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ED,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_INTEG,
        ST_MUL_IG,
        ST_SUM,
        ST_MUL_DUTY,
        ST_DONE
    } ctl_state_t;

endpackage

// ===== rtl/pihc_mul.sv =====
// ============================================================================
// pihc_mul
// Shared signed multiplier with a registered product, reused for every
// product of the control law.
// ============================================================================
module pihc_mul
    import pihc_pkg::*;
(
    input  logic                      clk,
    input  mul_req_t                  req,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    // Load a new product when enabled, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= $signed(req.a) * $signed(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/pihc_div.sv =====
// ============================================================================
// pihc_div
// Division by the fixed time-scale constant in two long-division steps, each
// a reciprocal multiplication on the shared multiplier.
// ============================================================================
module pihc_div
    import pihc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  div_req_t                  req,
    input  logic signed [MUL_P_W-1:0] prod,
    output mul_req_t                  mul,
    output div_rsp_t                  rsp
);

    div_phase_t           phase_reg, phase_next;
    logic [DIV_HI_W-1:0]  hi_reg;
    logic [DIV_LO_W-1:0]  lo_reg;
    logic [DIV_QH_W-1:0]  qh_reg;
    logic [DIV_Q_W-1:0]   quot_reg;
    logic [DIV_HI_W-1:0]  rem_full;
    logic [DIV_HI_W-1:0]  lo_num;

    // Sequence the three products: high quotient, its remainder, low quotient
    always_comb
    begin
        rem_full   = hi_reg - prod[DIV_HI_W-1:0];
        lo_num     = {rem_full[DIV_REM_W-1:0], lo_reg};
        phase_next = phase_reg;
        mul.en     = 1'b0;
        mul.a      = '0;
        mul.b      = '0;
        unique case (phase_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = DIV_HI;
                end
            end
            DIV_HI:
            begin
                mul.en     = 1'b1;
                mul.a      = $signed(MUL_A_W'(hi_reg));
                mul.b      = $signed(MUL_B_W'(RECIP));
                phase_next = DIV_REM;
            end
            DIV_REM:
            begin
                mul.en     = 1'b1;
                mul.a      = $signed(MUL_A_W'(prod[RECIP_SHIFT +: DIV_QH_W]));
                mul.b      = $signed(MUL_B_W'(DIVISOR));
                phase_next = DIV_LO;
            end
            DIV_LO:
            begin
                mul.en     = 1'b1;
                mul.a      = $signed(MUL_A_W'(lo_num));
                mul.b      = $signed(MUL_B_W'(RECIP));
                phase_next = DIV_FIN;
            end
            DIV_FIN:
            begin
                phase_next = DIV_IDLE;
            end
            default:
            begin
                phase_next = DIV_IDLE;
            end
        endcase
    end

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DIV_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Split numerator, high quotient and final quotient
    always_ff @(posedge clk)
    begin
        if (req.start && (phase_reg == DIV_IDLE))
        begin
            hi_reg <= req.num[DIV_N_W-1 -: DIV_HI_W];
            lo_reg <= req.num[DIV_LO_W-1:0];
        end
        if (phase_reg == DIV_REM)
        begin
            qh_reg <= prod[RECIP_SHIFT +: DIV_QH_W];
        end
        if (phase_reg == DIV_FIN)
        begin
            quot_reg <= {qh_reg, prod[RECIP_SHIFT +: DIV_QL_W]};
        end
    end

    assign rsp.busy = (phase_reg != DIV_IDLE);
    assign rsp.quot = quot_reg;

endmodule

// ===== rtl/pihc_core.sv =====
// ============================================================================
// pihc_core
// Sequencer and datapath of the PI law: error, elapsed time, integral with
// clamp, drive with clamp and PWM scaling, all through the shared multiplier,
// which the reciprocal divider borrows while it runs.
// ============================================================================
module pihc_core
    import pihc_pkg::*;
#(
    parameter int PWM_TOP = PWM_TOP_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    input  in_word_t  in_word,
    output logic      in_ready,
    output logic      res_valid,
    input  logic      res_ready,
    output out_word_t res
);

    ctl_state_t state_reg, state_next;

    logic signed [ERR_W-1:0]   err_reg;
    logic [TS_W-1:0]           dt_reg;
    logic [TS_W-1:0]           last_ts_reg;
    logic                      primed_reg;
    logic signed [INTEG_W-1:0] acc_reg;
    logic                      neg_reg;
    logic signed [PTERM_W-1:0] pterm_reg;
    logic [DRIVE_W-1:0]        drive_reg;

    mul_req_t                  mul_req;
    mul_req_t                  div_mul;
    logic signed [MUL_P_W-1:0] prod;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic                      accept;
    logic [MUL_P_W-1:0]        prod_mag;
    logic signed [DIV_Q_W:0]   q_signed;
    logic signed [DIV_Q_W+1:0] integ_sum;
    logic signed [DIV_Q_W+1:0] lim_pos;
    logic signed [DIV_Q_W+1:0] lim_neg;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [SUM_W-1:0]   drive_sum;
    logic [DRIVE_W-1:0]        drive_new;

    pihc_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    pihc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .prod  (prod),
        .mul   (div_mul),
        .rsp   (div_rsp)
    );

    assign accept = in_valid && in_ready;

    // Magnitude of err*dt, scaled by 4 as divider numerator
    assign prod_mag = prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);

    // Signed increment, integral sum and clamp
    always_comb
    begin
        q_signed  = neg_reg ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
        integ_sum = (DIV_Q_W+2)'(acc_reg) + (DIV_Q_W+2)'(q_signed);
        lim_pos   = $signed((DIV_Q_W+2)'(cfg.integ_limit));
        lim_neg   = -lim_pos;
        if (integ_sum > lim_pos)
        begin
            integ_new = INTEG_W'(lim_pos);
        end
        else if (integ_sum < lim_neg)
        begin
            integ_new = INTEG_W'(lim_neg);
        end
        else
        begin
            integ_new = INTEG_W'(integ_sum);
        end
    end

    // Drive sum in Q24 and clamp to 0..1
    always_comb
    begin
        drive_sum = (SUM_W'(pterm_reg) <<< 8) + SUM_W'($signed(prod[ITERM_W-1:0]));
        if (drive_sum < 0)
        begin
            drive_new = '0;
        end
        else if (drive_sum > $signed(SUM_W'(DRIVE_ONE)))
        begin
            drive_new = DRIVE_ONE;
        end
        else
        begin
            drive_new = DRIVE_W'(drive_sum);
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, multiplier operands and divider start
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mul_req.en    = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        div_req.start = 1'b0;
        div_req.num   = {prod_mag[DIV_N_W-3:0], 2'b00};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_MUL_ED;
                end
            end
            ST_MUL_ED:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed({1'b0, dt_reg});
                mul_req.b  = MUL_B_W'(err_reg);
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                // Hand the multiplier to the divider
                mul_req = div_mul;
                if (!div_rsp.busy)
                begin
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(err_reg);
                mul_req.b  = $signed(MUL_B_W'(cfg.prop_gain));
                state_next = ST_MUL_IG;
            end
            ST_MUL_IG:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(acc_reg);
                mul_req.b  = $signed(MUL_B_W'(cfg.integ_gain));
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_MUL_DUTY;
            end
            ST_MUL_DUTY:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed(MUL_A_W'(drive_reg));
                mul_req.b  = $signed(MUL_B_W'(PWM_TOP));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller state kept across words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ts_reg <= '0;
            primed_reg  <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                last_ts_reg <= in_word.timestamp_us;
                primed_reg  <= 1'b1;
            end
            if (state_reg == ST_INTEG)
            begin
                acc_reg <= integ_new;
            end
        end
    end

    // Working registers of one word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg <= ERR_W'(cfg.setpoint) - ERR_W'(in_word.temperature);
            dt_reg  <= primed_reg ? (in_word.timestamp_us - last_ts_reg) : '0;
        end
        if (state_reg == ST_DIV_START)
        begin
            neg_reg <= prod[MUL_P_W-1];
        end
        if (state_reg == ST_MUL_IG)
        begin
            pterm_reg <= prod[PTERM_W-1:0];
        end
        if (state_reg == ST_SUM)
        begin
            drive_reg <= drive_new;
        end
    end

    // Scale the Q24 drive down to a compare count
    assign res.duty_count   = prod[DRIVE_FRAC +: DUTY_W];
    assign res.integral_out = acc_reg;

    // Divider is free whenever a new division is launched
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_START) |-> !div_rsp.busy)
        else $error("division launched while divider busy");

    // Clamped drive never exceeds full scale when it is scaled
    a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_DUTY) |-> (drive_reg <= DRIVE_ONE))
        else $error("drive above full scale");

    // Compare count stays within the PWM period
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((PWM_TOP > 16383) || (32'(res.duty_count) <= 32'(PWM_TOP))))
        else $error("duty count above PWM top");

    // A word is taken only after the previous result is handed over
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MUL_ED) && !res_valid)
        else $error("word taken while another is in flight");

endmodule

// ===== rtl/pi_heater_temperature_control.sv =====
// ============================================================================
// pi_heater_temperature_control
// PI heater controller with integrator clamp. Each input word (temperature in
// 1/256 degC and a microsecond timestamp) produces one output word: a PWM
// compare count 0..PWM_TOP and the clamped integral in 1/65536 degC*s. The
// first word after reset counts as zero elapsed time. One word is processed
// at a time. Every product runs through a single shared 33x33 multiplier;
// the division of error*time by the time-scale constant takes three of those
// products as two reciprocal long-division steps. The result sits in an output
// register, so the next word is taken while it waits. Configuration registers
// are written through a plain write port and must only change while the
// block is idle.
// ============================================================================
module pi_heater_temperature_control
    import pihc_pkg::*;
#(
    parameter int PWM_TOP = PWM_TOP_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data
);

    cfg_t      cfg_reg;
    logic      in_ready;
    logic      res_valid;
    logic      res_ready;
    out_word_t res;
    logic      out_valid_reg;
    out_word_t out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint    <= SETPOINT_RST;
            cfg_reg.prop_gain   <= PROP_GAIN_RST;
            cfg_reg.integ_gain  <= INTEG_GAIN_RST;
            cfg_reg.integ_limit <= INTEG_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETPOINT:    cfg_reg.setpoint    <= $signed(cfg_data[TEMP_W-1:0]);
                REG_PROP_GAIN:   cfg_reg.prop_gain   <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  cfg_reg.integ_gain  <= cfg_data[GAIN_W-1:0];
                REG_INTEG_LIMIT: cfg_reg.integ_limit <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    pihc_core #(
        .PWM_TOP (PWM_TOP)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_word   (in_data),
        .in_ready  (in_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign in_stall  = !in_ready;
    assign res_ready = !out_valid_reg || !out_stall;

    // Output register: load a new word when empty or drained, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/sv/pi_heater_temperature_control_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pi_heater_temperature_control_tb
// Self-checking bench for the PI heater controller. A scoreboard class keeps
// its own copy of the registers and the integrator state. It predicts duty
// count and clamped integral for every accepted input word and checks each
// output word against the oldest prediction. The stimulus starts with
// directed words for the field extremes, the first-sample case, timestamp
// wrap and long intervals, and a zero integrator clamp. Random words follow
// under several register settings and three idling patterns.
// ============================================================================
module pi_heater_temperature_control_tb;
    import pihc_pkg::*;

    localparam int     DRAIN_CYCLES = 80;
    localparam int     SHOWN_MAX    = 10;
    localparam int     RAND_ITEMS   = 205;
    localparam int     HOLD_CYCLES  = 300;
    localparam longint US_PER_S     = 1000000;
    localparam longint FULL_DRIVE   = longint'(DRIVE_ONE);

    // Predict and check output words against a private copy of the state
    class pi_drive_board;
        cfg_t                      regs;
        logic signed [INTEG_W-1:0] integ_acc;
        logic [TS_W-1:0]           last_ts;
        bit                        primed;
        out_word_t                 pending_words[$];
        int                        mismatches;

        function new();
            regs.setpoint    = SETPOINT_RST;
            regs.prop_gain   = PROP_GAIN_RST;
            regs.integ_gain  = INTEG_GAIN_RST;
            regs.integ_limit = INTEG_LIMIT_RST;
            integ_acc        = '0;
            last_ts          = '0;
            primed           = 1'b0;
            mismatches       = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SETPOINT:    regs.setpoint    = val[TEMP_W-1:0];
                REG_PROP_GAIN:   regs.prop_gain   = val[GAIN_W-1:0];
                REG_INTEG_GAIN:  regs.integ_gain  = val[GAIN_W-1:0];
                REG_INTEG_LIMIT: regs.integ_limit = val[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the integrator on one sample and queue the expected word
        function void take_sample(in_word_t w);
            logic [TS_W-1:0] diff;
            longint          err;
            longint          dt;
            longint          integ;
            longint          lim;
            longint          drive;
            longint          duty;
            out_word_t       want;
            err  = longint'($signed(regs.setpoint)) - longint'($signed(w.temperature));
            diff = w.timestamp_us - last_ts;
            dt   = primed ? longint'({32'd0, diff}) : 64'sd0;
            last_ts = w.timestamp_us;
            primed  = 1'b1;

            // Accumulate, truncating toward zero, then clamp to the limit
            lim   = regs.integ_limit;
            integ = longint'($signed(integ_acc)) + (err * dt * 256) / US_PER_S;
            if (integ > lim)
                integ = lim;
            if (integ < -lim)
                integ = -lim;
            integ_acc = INTEG_W'(integ);

            // Form the Q24 drive, clamp to 0..1 and scale to the PWM count
            drive = longint'(regs.prop_gain) * err * 256
                  + longint'(regs.integ_gain) * integ;
            if (drive < 0)
                drive = 0;
            if (drive > FULL_DRIVE)
                drive = FULL_DRIVE;
            duty = (drive * PWM_TOP_DEF) >>> DRIVE_FRAC;

            want.duty_count   = DUTY_W'(duty);
            want.integral_out = INTEG_W'(integ);
            pending_words.push_back(want);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            bit        bad;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("%0t: output word with none expected: duty %0d integral %0d",
                             $realtime, got.duty_count, got.integral_out);
                return;
            end
            want = pending_words.pop_front();
            bad  = 1'b0;
            if (got.duty_count !== want.duty_count)
                bad = 1'b1;
            if (got.integral_out !== want.integral_out)
                bad = 1'b1;
            if (bad)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("%0t: duty exp %0d got %0d, integral exp %0d got %0d",
                             $realtime, want.duty_count, got.duty_count,
                             want.integral_out, got.integral_out);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;

    pi_drive_board   board;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_left;
    logic [TS_W-1:0] ts_now;

    pi_heater_temperature_control uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        #10_000_000;
        $display("pi_heater_temperature_control: mismatch");
        $finish;
    end

    // Drive the output stall and check words that will be taken at the next edge
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_word(out_data);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // Offer one word after a random gap; return at the negedge before it is taken
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(posedge clk);
            in_valid <= 1'b0;
        end
        @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(negedge clk);
        while (in_stall);
        board.take_sample(w);
    endtask

    task automatic send_pair(input logic [TEMP_W-1:0] t, input logic [TS_W-1:0] ts);
        in_word_t w;
        w.temperature  = t;
        w.timestamp_us = ts;
        send_word(w);
    endtask

    task automatic end_burst();
        @(posedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every predicted word has come back, then let the block settle
    task automatic drain();
        do
            @(negedge clk);
        while (board.pending_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(600));
        endcase
    endfunction

    // Load a random setting, extremes included, with junk above the narrow fields
    task automatic load_random_setting();
        logic [CFG_DATA_W-1:0] v;
        logic [6:0]            junk;
        junk = 7'($urandom);
        case ($urandom_range(7))
            0:       v = {junk, 16'h8000};
            1:       v = {junk, 16'h7FFF};
            2, 3:    v = {junk, 16'($urandom)};
            default: v = {junk, 16'(14080 + $urandom_range(4096) - 2048)};
        endcase
        write_reg(REG_SETPOINT, v);
        write_reg(REG_PROP_GAIN, {7'($urandom), pick_gain()});
        write_reg(REG_INTEG_GAIN, {7'($urandom), pick_gain()});
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = 23'h7F_FFFF;
            2:       v = CFG_DATA_W'($urandom);
            default: v = CFG_DATA_W'($urandom_range(32'h0010_0000));
        endcase
        write_reg(REG_INTEG_LIMIT, v);
    endtask

    // Mostly 100 ms samples near the setpoint; some jumps, repeats and noise
    function automatic in_word_t next_sample();
        in_word_t w;
        int       pick;
        int       span;
        int       t;
        pick = $urandom_range(99);
        if (pick < 4)
            ts_now = $urandom;
        else if (pick < 7)
            ts_now = ts_now - $urandom_range(1000);
        else if (pick < 13)
            ts_now = ts_now + $urandom_range(32'h00FF_FFFF);
        else if (pick >= 15)
            ts_now = ts_now + 32'd98000 + $urandom_range(4000);
        w.timestamp_us = ts_now;
        if ($urandom_range(99) < 10)
            w.temperature = TEMP_W'($urandom);
        else
        begin
            case ($urandom_range(2))
                0:       span = 64;
                1:       span = 1024;
                default: span = 8192;
            endcase
            t = int'($signed(board.regs.setpoint)) + int'($urandom_range(2 * span)) - span;
            w.temperature = TEMP_W'(t);
        end
        return w;
    endfunction

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_SETPOINT;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        out_stall     <= 1'b0;
        send_idle_pct = 14;
        recv_idle_pct = 64;
        hold_left     = 0;
        ts_now        = '0;
        board         = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: first sample, error extremes, wrap and long intervals
        send_pair(16'd14080, 32'h1234_5678);
        send_pair(16'd13824, 32'h1235_DCF8);
        send_pair(16'h8000, 32'h1237_6398);
        send_pair(16'h7FFF, 32'h1238_EA38);
        send_pair(16'h0000, 32'hFFFF_FFF0);
        send_pair(16'd14080, 32'h0000_0010);
        send_pair(16'd14208, 32'h0000_000F);
        send_pair(16'd14080, 32'h0000_000F);
        end_burst();
        drain();

        // Extreme registers, with bits above the field widths set
        write_reg(REG_SETPOINT, 23'h7F_8000);
        write_reg(REG_PROP_GAIN, 23'h7F_FFFF);
        write_reg(REG_INTEG_GAIN, 23'h7F_FFFF);
        write_reg(REG_INTEG_LIMIT, 23'h7F_FFFF);
        send_pair(16'h7FFF, 32'hFFFF_FFFF);
        send_pair(16'h8000, 32'h0000_0000);
        send_pair(16'h7FFF, 32'h8000_0000);
        send_pair(16'h8000, 32'hFFFF_FFFF);
        end_burst();
        drain();

        // Zero gains and a zero clamp hold the integral at zero
        write_reg(REG_SETPOINT, 23'h00_7FFF);
        write_reg(REG_PROP_GAIN, 23'h00_0000);
        write_reg(REG_INTEG_GAIN, 23'h00_0000);
        write_reg(REG_INTEG_LIMIT, 23'h00_0000);
        send_pair(16'h8000, 32'h4000_0000);
        send_pair(16'h7FFF, 32'h4000_0001);
        end_burst();
        drain();

        // Tight clamp with strong gains
        write_reg(REG_SETPOINT, 23'h55_3700);
        write_reg(REG_PROP_GAIN, 23'h00_0800);
        write_reg(REG_INTEG_GAIN, 23'h00_0100);
        write_reg(REG_INTEG_LIMIT, 23'h00_0001);
        send_pair(16'd13980, 32'h5000_0000);
        send_pair(16'd14180, 32'h5001_0000);
        send_pair(16'd14080, 32'h5002_0000);
        end_burst();
        drain();

        // Random words under three idling patterns, two settings each
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int setting = 0; setting < 2; setting++)
            begin
                load_random_setting();
                if ($urandom_range(1))
                    ts_now = 32'hFFF0_0000 + $urandom_range(32'h000F_0000);
                for (int n = 0; n < RAND_ITEMS; n++)
                begin
                    // Hold off the output so the block backs up into the input
                    if (n == 60)
                        hold_left = HOLD_CYCLES;
                    // Pause the input until everything has come back
                    if (n == 140)
                    begin
                        end_burst();
                        drain();
                    end
                    send_word(next_sample());
                end
                end_burst();
                drain();
            end
        end

        if (board.mismatches == 0 && board.pending_words.size() == 0)
            $display("pi_heater_temperature_control: match");
        else
            $display("pi_heater_temperature_control: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pihc_pkg.sv
rtl/pihc_mul.sv
rtl/pihc_div.sv
rtl/pihc_core.sv
rtl/pi_heater_temperature_control.sv
tb/sv/pi_heater_temperature_control_tb.sv
